// ===== design/iabst_pkg.sv =====
// ----------------------------------------------------------------------------
// iabst_pkg
// shared types and constants for the implicit array binary search tree
// ----------------------------------------------------------------------------
package iabst_pkg;

	localparam int SlotsDef = 256;
	localparam int KeyW     = 32;
	localparam int CountW   = 9;

	localparam logic [CountW-1:0] CountMax = '1;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_MIN    = 2'd2,
		OP_MAX    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_ZERO  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic clr_step;
		logic accept;
		logic walk;
		logic out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;
		logic walk_done;
	} sts_t;

endpackage

// ===== design/iabst_dp.sv =====
// ----------------------------------------------------------------------------
// iabst_dp
// slot store, walk index, compare and result registers
// ----------------------------------------------------------------------------
module iabst_dp #(
	parameter int SLOTS = iabst_pkg::SlotsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  iabst_pkg::cmd_t                   cmd,
	output iabst_pkg::sts_t                   sts,
	input  logic [1:0]                        operation,
	input  logic signed [iabst_pkg::KeyW-1:0] key,
	output logic                              found,
	output logic signed [iabst_pkg::KeyW-1:0] value,
	output logic [iabst_pkg::CountW-1:0]      count,
	output logic [1:0]                        status
);

	localparam int IdxW = $clog2(SLOTS);
	localparam logic [IdxW:0] SlotsLim = (IdxW+1)'(SLOTS);

	logic signed [iabst_pkg::KeyW-1:0] mem [SLOTS];

	iabst_pkg::op_t                    op_q;
	logic signed [iabst_pkg::KeyW-1:0] key_q;
	logic [IdxW-1:0]                   idx_q;
	logic signed [iabst_pkg::KeyW-1:0] best_q;
	logic signed [iabst_pkg::KeyW-1:0] rdata_q;
	logic [IdxW-1:0]                   clr_idx_q;
	logic [iabst_pkg::CountW-1:0]      count_q;

	logic                              res_found_q;
	logic signed [iabst_pkg::KeyW-1:0] res_value_q;
	iabst_pkg::status_t                res_status_q;

	logic                              found_q;
	logic signed [iabst_pkg::KeyW-1:0] value_q;
	iabst_pkg::status_t                status_q;
	logic [iabst_pkg::CountW-1:0]      count_out_q;

	logic                              go_right;
	logic [IdxW:0]                     nxt;
	logic                              off_end;
	logic                              is_root;
	logic                              cur_zero;
	logic                              key_zero;
	logic                              done;
	logic                              ins_wr;
	logic                              r_found;
	logic signed [iabst_pkg::KeyW-1:0] r_value;
	iabst_pkg::status_t                r_status;
	logic [IdxW-1:0]                   raddr;
	logic                              we;
	logic [IdxW-1:0]                   waddr;
	logic signed [iabst_pkg::KeyW-1:0] wdata;

	// child index: 2i for left, 2i+1 for right
	always_comb begin
		case (op_q)
			iabst_pkg::OP_MAX: go_right = 1'b1;
			iabst_pkg::OP_MIN: go_right = 1'b0;
			default:           go_right = !(key_q < rdata_q);
		endcase
	end

	assign nxt      = {idx_q, go_right};
	assign off_end  = nxt >= SlotsLim;
	assign is_root  = idx_q == IdxW'(1);
	assign cur_zero = rdata_q == '0;
	assign key_zero = key_q == '0;

	// one tree level per cycle
	always_comb begin
		done     = 1'b0;
		ins_wr   = 1'b0;
		r_found  = 1'b0;
		r_value  = key_q;
		r_status = iabst_pkg::ST_OK;
		case (op_q)
			iabst_pkg::OP_INSERT: begin
				if (key_zero) begin
					done     = 1'b1;
					r_value  = '0;
					r_status = iabst_pkg::ST_ZERO;
				end else if (cur_zero) begin
					done   = 1'b1;
					ins_wr = 1'b1;
				end else if (off_end) begin
					done     = 1'b1;
					r_status = iabst_pkg::ST_FULL;
				end
			end
			iabst_pkg::OP_SEARCH: begin
				if (key_zero) begin
					done     = 1'b1;
					r_value  = '0;
					r_status = iabst_pkg::ST_ZERO;
				end else if (cur_zero) begin
					done     = 1'b1;
					r_status = is_root ? iabst_pkg::ST_EMPTY : iabst_pkg::ST_OK;
				end else if (rdata_q == key_q) begin
					done    = 1'b1;
					r_found = 1'b1;
				end else if (off_end) begin
					done = 1'b1;
				end
			end
			iabst_pkg::OP_MIN, iabst_pkg::OP_MAX: begin
				if (cur_zero) begin
					done = 1'b1;
					if (is_root) begin
						r_value  = '0;
						r_status = iabst_pkg::ST_EMPTY;
					end else begin
						r_found = 1'b1;
						r_value = best_q;
					end
				end else if (off_end) begin
					done    = 1'b1;
					r_found = 1'b1;
					r_value = rdata_q;
				end
			end
			default: done = 1'b1;
		endcase
	end

	assign sts.walk_done = cmd.walk & done;
	assign sts.clr_last  = clr_idx_q == IdxW'(SLOTS - 1);

	assign raddr = cmd.walk ? nxt[IdxW-1:0] : IdxW'(1);
	assign we    = cmd.clr_step | (cmd.walk & ins_wr);
	assign waddr = cmd.clr_step ? clr_idx_q : idx_q;
	assign wdata = cmd.clr_step ? '0 : key_q;

	// slot store
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	// walk and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= iabst_pkg::op_t'(operation);
			key_q <= key;
			idx_q <= IdxW'(1);
		end else if (cmd.walk && !done) begin
			idx_q  <= nxt[IdxW-1:0];
			best_q <= rdata_q;
		end
		if (cmd.walk && done) begin
			res_found_q  <= r_found;
			res_value_q  <= r_value;
			res_status_q <= r_status;
		end
		if (cmd.out_load) begin
			found_q     <= res_found_q;
			value_q     <= res_value_q;
			status_q    <= res_status_q;
			count_out_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			count_q   <= '0;
		end else begin
			if (cmd.clr_step) begin
				clr_idx_q <= clr_idx_q + IdxW'(1);
			end
			if (cmd.walk && ins_wr && count_q != iabst_pkg::CountMax) begin
				count_q <= count_q + iabst_pkg::CountW'(1);
			end
		end
	end

	assign found  = found_q;
	assign value  = value_q;
	assign count  = count_out_q;
	assign status = status_q;

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q >= $past(count_q))
		else $error("key count went down");

	a_no_zero_store: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk && ins_wr) |-> !key_zero)
		else $error("zero key written to slot store");

endmodule

// ===== design/iabst_ctrl.sv =====
// ----------------------------------------------------------------------------
// iabst_ctrl
// sequencer for clearing pass, tree walk and result handoff
// ----------------------------------------------------------------------------
module iabst_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  iabst_pkg::sts_t sts,
	output iabst_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_WALK   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = state_q == S_IDLE;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_WALK;
				end
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_done) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_accept_to_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> state_q == S_WALK)
		else $error("accepted beat did not start a walk");

	a_hold_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FINISH && out_valid_q && !out_ready) |=> state_q == S_FINISH)
		else $error("result left finish while output beat was stalled");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("output register overwritten before its beat was taken");

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_step |-> !in_ready && !cmd.walk)
		else $error("input taken during clearing pass");

endmodule

// ===== design/implicit_array_bst_table.sv =====
// walk: an accepted beat walks the tree levels, one per cycle, and then waits for a
//   free output register before out_valid rises; an insert or search with a zero key
//   ends its walk at the root
// throughput: one item at a time; one slot store read per cycle sets the walk rate
// reset: arst_n clears control state, then a clearing pass zeroes every slot of the
//   slot store while in_ready stays low
// ----------------------------------------------------------------------------
// implicit_array_bst_table
// binary search tree in an implicitly indexed slot store (insert, search, min, max)
// ----------------------------------------------------------------------------
module implicit_array_bst_table #(
	parameter int SLOTS = iabst_pkg::SlotsDef
) (
	input  logic                              clk,
	input  logic                              arst_n,

	// request channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic signed [iabst_pkg::KeyW-1:0] key,

	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              found,
	output logic signed [iabst_pkg::KeyW-1:0] value,
	output logic [iabst_pkg::CountW-1:0]      count,
	output logic [1:0]                        status
);

	// root lives at slot 1, slot i has children 2i and 2i+1; zero marks empty
	iabst_pkg::cmd_t cmd;
	iabst_pkg::sts_t sts;

	// sequencer: clearing pass, accept, walk, result handoff
	iabst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot store, signed compare and child index, output beat registers
	iabst_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.operation (operation),
		.key       (key),
		.found     (found),
		.value     (value),
		.count     (count),
		.status    (status)
	);

endmodule
